FILE: sv/abac_pkg.sv
// Shared types and constants of the ADPCM buffer address controller.
package abac_pkg;

	localparam int unsigned ADDR_W = 16;
	localparam int unsigned BUFFER_BYTES = 65536;
	localparam logic [3:0] WRITE_DELAY = 4'd3;
	localparam logic [3:0] READ_DELAY = 4'd3;
	localparam logic [15:0] HALF_MARK = 16'h8000;
	localparam logic [15:0] LEN_MAX = 16'hffff;
	localparam logic [8:0] RATE_MAX = 9'd256;

	// Mode flag bit positions.
	localparam int unsigned MF_WOFS = 0;
	localparam int unsigned MF_WLAT = 1;
	localparam int unsigned MF_ROFS = 2;
	localparam int unsigned MF_RLAT = 3;
	localparam int unsigned MF_LLAT = 4;
	localparam int unsigned MF_PLAY = 5;
	localparam int unsigned MF_NREP = 6;
	localparam int unsigned MF_RST = 7;

	// Interrupt flag bit positions.
	localparam int unsigned IRQ_HALF = 0;
	localparam int unsigned IRQ_END = 1;

	// Item commands.
	typedef enum logic [2:0] {
		CMD_TICK    = 3'd0,
		CMD_SAMPLE  = 3'd1,
		CMD_CONTROL = 3'd2,
		CMD_LATCH   = 3'd3,
		CMD_DMA     = 3'd4,
		CMD_READ    = 3'd5,
		CMD_NONE6   = 3'd6,
		CMD_NONE7   = 3'd7
	} cmd_t;

	// Configuration register indexes.
	typedef enum logic {
		REG_RATE = 1'b0,
		REG_DMA  = 1'b1
	} reg_t;

	// What the data stage does with the play byte.
	typedef enum logic [1:0] {
		PB_KEEP,
		PB_CLEAR,
		PB_LOAD,
		PB_SHIFT
	} pb_op_t;

	// Work handed from the address stage to the data stage.
	typedef struct packed {
		logic         rh_load;
		logic         rh_clear;
		pb_op_t       pb_op;
		logic         fwd;
		logic [7:0]   fwd_data;
		logic         half;
		logic         fin;
		logic         playing;
		logic         taken;
		logic [15:0]  length;
	} stage_t;

endpackage

FILE: sv/abac_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module abac_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: sv/adpcm_buffer_address_controller.sv
// Top level of the ADPCM sample buffer address controller.
// The block accepts an item in every cycle that in_ready is high and returns one result per
// item through the address stage, data stage and output register. The address stage updates
// the pointers, counters and flags and issues at most one read and one write to the 64 KiB
// sample RAM; the data stage takes the RAM read data into the CPU read byte or the play byte
// and registers the result. A write and a read of the same address on one bus tick are forwarded.
// Sample RAM contents are undefined until written; there is no clearing pass after reset.
module adpcm_buffer_address_controller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  command,
	input  logic [7:0]  data_byte,
	input  logic [15:0] latch_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  read_byte,
	output logic [3:0]  nibble,
	output logic        nibble_valid,
	output logic        half_irq,
	output logic        end_irq,
	output logic        is_playing,
	output logic        dma_taken,
	output logic [15:0] remaining_length
);

	logic [8:0]  rate_q;
	logic        dma_en_q;
	logic [15:0] rp_q, wp_q, len_q, latch_q;
	logic [3:0]  ww_q, rw_q;
	logic [7:0]  wh_q, mode_q, pc_q;
	logic [1:0]  irq_q;
	logic        ph_q;
	logic [7:0]  rh_q, pb_q;
	logic        s1_valid_q;
	abac_pkg::stage_t s1_q;
	logic        o_valid_q;
	logic [3:0]  o_nib_q;
	logic        o_nv_q, o_half_q, o_end_q, o_play_q, o_taken_q;
	logic [15:0] o_len_q;

	logic        in_acc, adv, cfg_wr;
	logic [15:0] rp_n, wp_n, len_n, latch_n;
	logic [3:0]  ww_n, rw_n;
	logic [7:0]  wh_n, mode_n, pc_n, m;
	logic [1:0]  irq_n;
	logic        ph_n;
	logic [8:0]  div, nxt;
	logic        mem_we, mem_re;
	logic [15:0] mem_wa, mem_ra;
	logic [7:0]  mem_wd, mem_rd;
	abac_pkg::stage_t st;
	logic [7:0]  d, rh_n, pb_n;
	logic [3:0]  code;
	logic        code_v;

	abac_ram #(.WIDTH(8), .DEPTH(abac_pkg::BUFFER_BYTES)) u_buf (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_wa),
		.wdata (mem_wd),
		.re    (mem_re),
		.raddr (mem_ra),
		.rdata (mem_rd)
	);

	// Handshake: the data stage moves on when the output register is free.
	assign adv      = !o_valid_q || out_ready;
	assign in_ready = !s1_valid_q || adv;
	assign in_acc   = in_valid && in_ready;
	assign mem_re   = in_acc;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	always_comb begin
		unique case (abac_pkg::reg_t'(paddr[2]))
			abac_pkg::REG_RATE: prdata = {23'd0, rate_q};
			abac_pkg::REG_DMA:  prdata = {31'd0, dma_en_q};
			default:            prdata = 32'd0;
		endcase
	end

	// Address stage: next state of the counters and flags, and the RAM accesses.
	always_comb begin
		rp_n = rp_q; wp_n = wp_q; len_n = len_q; latch_n = latch_q;
		ww_n = ww_q; rw_n = rw_q; wh_n = wh_q; mode_n = mode_q; pc_n = pc_q;
		irq_n = irq_q; ph_n = ph_q; m = mode_q;
		mem_we = 1'b0; mem_wa = wp_q; mem_wd = wh_q; mem_ra = rp_q;
		div = 9'd0; nxt = 9'd0;
		st = '0;
		st.pb_op = abac_pkg::PB_KEEP;
		unique case (abac_pkg::cmd_t'(command))
			abac_pkg::CMD_TICK, abac_pkg::CMD_DMA: begin
				if (ww_q != 4'd0) begin
					ww_n = ww_q - 4'd1;
					if (ww_n == 4'd0) begin
						irq_n[abac_pkg::IRQ_HALF] = len_n < abac_pkg::HALF_MARK;
						if (!mode_q[abac_pkg::MF_LLAT] && len_n < abac_pkg::LEN_MAX) begin
							len_n = len_n + 16'd1;
						end
						mem_we = 1'b1;
						wp_n = wp_q + 16'd1;
					end
				end
				if (command == abac_pkg::CMD_DMA && dma_en_q && ww_n == 4'd0) begin
					ww_n = abac_pkg::WRITE_DELAY;
					wh_n = data_byte;
					st.taken = 1'b1;
				end
				if (rw_q != 4'd0) begin
					rw_n = rw_q - 4'd1;
					if (rw_n == 4'd0) begin
						st.rh_load = 1'b1;
						st.fwd = mem_we && (wp_q == rp_q);
						st.fwd_data = wh_q;
						rp_n = rp_q + 16'd1;
						irq_n[abac_pkg::IRQ_HALF] = len_n < abac_pkg::HALF_MARK;
						if (!mode_q[abac_pkg::MF_LLAT]) begin
							if (len_n != 16'd0) begin
								len_n = len_n - 16'd1;
							end else begin
								irq_n[abac_pkg::IRQ_HALF] = 1'b0;
								irq_n[abac_pkg::IRQ_END] = 1'b1;
								if (mode_q[abac_pkg::MF_NREP]) mode_n[abac_pkg::MF_PLAY] = 1'b0;
							end
						end
					end
				end
			end
			abac_pkg::CMD_SAMPLE: begin
				div = (rate_q > abac_pkg::RATE_MAX) ? abac_pkg::RATE_MAX : rate_q;
				nxt = {1'b0, pc_q} + 9'd1;
				if (nxt < div) begin
					pc_n = nxt[7:0];
				end else begin
					pc_n = 8'd0;
					if (mode_q[abac_pkg::MF_PLAY]) begin
						if (!ph_q) begin
							st.pb_op = abac_pkg::PB_LOAD;
							rp_n = rp_q + 16'd1;
							if (!mode_q[abac_pkg::MF_LLAT] && len_q != 16'd0) begin
								len_n = len_q - 16'd1;
							end
						end else begin
							st.pb_op = abac_pkg::PB_SHIFT;
						end
						ph_n = !ph_q;
						irq_n[abac_pkg::IRQ_HALF] = len_n < abac_pkg::HALF_MARK;
						if (!mode_q[abac_pkg::MF_LLAT] && len_n == 16'd0) begin
							irq_n[abac_pkg::IRQ_HALF] = 1'b0;
							irq_n[abac_pkg::IRQ_END] = 1'b1;
							if (mode_q[abac_pkg::MF_NREP]) mode_n[abac_pkg::MF_PLAY] = 1'b0;
						end
					end
				end
			end
			abac_pkg::CMD_CONTROL: begin
				m[abac_pkg::MF_WOFS] = data_byte[abac_pkg::MF_WOFS];
				if (!m[abac_pkg::MF_WLAT] && data_byte[abac_pkg::MF_WLAT]) begin
					wp_n = latch_q - {15'd0, !m[abac_pkg::MF_WOFS]};
				end
				m[abac_pkg::MF_WLAT] = data_byte[abac_pkg::MF_WLAT];
				m[abac_pkg::MF_ROFS] = data_byte[abac_pkg::MF_ROFS];
				if (!m[abac_pkg::MF_RLAT] && data_byte[abac_pkg::MF_RLAT]) begin
					rp_n = latch_q - {15'd0, !m[abac_pkg::MF_ROFS]};
				end
				m[abac_pkg::MF_RLAT] = data_byte[abac_pkg::MF_RLAT];
				m[abac_pkg::MF_LLAT] = data_byte[abac_pkg::MF_LLAT];
				if (m[abac_pkg::MF_LLAT]) begin
					irq_n[abac_pkg::IRQ_END] = 1'b0;
					len_n = latch_q;
				end
				if (m[abac_pkg::MF_PLAY] && !data_byte[abac_pkg::MF_PLAY]) begin
					m[abac_pkg::MF_PLAY] = 1'b0;
				end else if (!m[abac_pkg::MF_PLAY] && data_byte[abac_pkg::MF_PLAY]) begin
					irq_n[abac_pkg::IRQ_HALF] = 1'b0;
					m[abac_pkg::MF_PLAY] = 1'b1;
					st.pb_op = abac_pkg::PB_CLEAR;
					ph_n = 1'b0;
				end
				m[abac_pkg::MF_NREP] = data_byte[abac_pkg::MF_NREP];
				if (irq_n[abac_pkg::IRQ_END] && m[abac_pkg::MF_NREP]) m[abac_pkg::MF_PLAY] = 1'b0;
				mode_n = m;
				if (data_byte[abac_pkg::MF_RST]) begin
					irq_n = 2'd0; mode_n = 8'd0;
					rp_n = 16'd0; rw_n = 4'd0; st.rh_clear = 1'b1;
					wp_n = 16'd0; ww_n = 4'd0; wh_n = 8'd0;
					st.pb_op = abac_pkg::PB_CLEAR; ph_n = 1'b0;
					latch_n = 16'd0; len_n = 16'd0;
				end
			end
			abac_pkg::CMD_LATCH: latch_n = latch_word;
			abac_pkg::CMD_READ:  rw_n = abac_pkg::READ_DELAY;
			default: ;
		endcase
		st.half    = irq_n[abac_pkg::IRQ_HALF];
		st.fin     = irq_n[abac_pkg::IRQ_END];
		st.playing = mode_n[abac_pkg::MF_PLAY];
		st.length  = len_n;
		mem_we = mem_we && in_acc;
	end

	// Data stage: resolve the read byte, the play byte and the nibble.
	always_comb begin
		d = s1_q.fwd ? s1_q.fwd_data : mem_rd;
		rh_n = rh_q;
		if (s1_q.rh_clear) rh_n = 8'd0;
		else if (s1_q.rh_load) rh_n = d;
		code = 4'd0; code_v = 1'b0; pb_n = pb_q;
		unique case (s1_q.pb_op)
			abac_pkg::PB_KEEP:  pb_n = pb_q;
			abac_pkg::PB_CLEAR: pb_n = 8'd0;
			abac_pkg::PB_LOAD: begin
				code = d[7:4]; code_v = 1'b1; pb_n = {d[3:0], 4'd0};
			end
			abac_pkg::PB_SHIFT: begin
				code = pb_q[7:4]; code_v = 1'b1; pb_n = {pb_q[3:0], 4'd0};
			end
			default: pb_n = pb_q;
		endcase
	end

	// Control state, configuration and both pipeline stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= 9'd1; dma_en_q <= 1'b0;
			rp_q <= '0; wp_q <= '0; len_q <= '0; latch_q <= '0;
			ww_q <= '0; rw_q <= '0; wh_q <= '0; mode_q <= '0; pc_q <= '0;
			irq_q <= '0; ph_q <= 1'b0; rh_q <= '0; pb_q <= '0;
			s1_valid_q <= 1'b0; o_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (abac_pkg::reg_t'(paddr[2]))
					abac_pkg::REG_RATE: rate_q <= pwdata[8:0];
					abac_pkg::REG_DMA:  dma_en_q <= pwdata[0];
					default: ;
				endcase
			end
			if (in_acc) begin
				rp_q <= rp_n; wp_q <= wp_n; len_q <= len_n; latch_q <= latch_n;
				ww_q <= ww_n; rw_q <= rw_n; wh_q <= wh_n; mode_q <= mode_n; pc_q <= pc_n;
				irq_q <= irq_n; ph_q <= ph_n;
			end
			if (in_ready) s1_valid_q <= in_valid;
			if (adv) o_valid_q <= s1_valid_q;
			if (adv && s1_valid_q) begin
				rh_q <= rh_n; pb_q <= pb_n;
			end
		end
	end

	// Payload registers of both stages.
	always_ff @(posedge clk) begin
		if (in_acc) s1_q <= st;
		if (adv && s1_valid_q) begin
			o_nib_q <= code; o_nv_q <= code_v;
			o_half_q <= s1_q.half; o_end_q <= s1_q.fin; o_play_q <= s1_q.playing;
			o_taken_q <= s1_q.taken; o_len_q <= s1_q.length;
		end
	end

	assign out_valid        = o_valid_q;
	assign read_byte        = rh_q;
	assign nibble           = o_nib_q;
	assign nibble_valid     = o_nv_q;
	assign half_irq         = o_half_q;
	assign end_irq          = o_end_q;
	assign is_playing       = o_play_q;
	assign dma_taken        = o_taken_q;
	assign remaining_length = o_len_q;

	// The delay slots never count beyond their load values.
	a_wwait: assert property (@(posedge clk) disable iff (!arst_n)
		ww_q <= abac_pkg::WRITE_DELAY) else $error("write delay out of range");
	a_rwait: assert property (@(posedge clk) disable iff (!arst_n)
		rw_q <= abac_pkg::READ_DELAY) else $error("read delay out of range");
	// An item in the data stage is kept while the output is stalled.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && o_valid_q && !out_ready) |=> s1_valid_q)
		else $error("data stage item lost under stall");

endmodule
